// File: rtl/svt_pkg.sv
// Shared types, constants and width helpers for the sparse voxel tree store.
`default_nettype none

package svt_pkg;

  localparam int unsigned DEF_CHUNK_GRID = 16;
  localparam int unsigned DEF_NODE_POOL  = 4096;

  localparam int unsigned COORD_W     = 4;
  localparam int unsigned MAT_W       = 8;
  localparam int unsigned SLOT_SEL_W  = 6;   // 64 slots per node
  localparam int unsigned MASK_W      = 64;
  localparam int unsigned GRID_CMP_W  = 7;   // holds the largest grid size

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Memory command bundle from the sequencer to the storage.
  typedef struct packed {
    logic root_re;
    logic root_we;
    logic mask_re;
    logic mask_we;
    logic slot_re;
    logic slot_we;
  } svt_mem_cmd_t;

  function automatic int unsigned idx_w(int unsigned n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

`default_nettype wire

// File: rtl/svt_store.sv
// Storage: chunk root table, node fill masks and node slots, single-port sync RAMs.
`default_nettype none

module svt_store import svt_pkg::*; #(
  parameter int unsigned CHUNK_GRID = DEF_CHUNK_GRID,
  parameter int unsigned NODE_POOL  = DEF_NODE_POOL,
  localparam int unsigned CHUNKS = CHUNK_GRID * CHUNK_GRID * CHUNK_GRID,
  localparam int unsigned CI_W   = idx_w(CHUNKS),
  localparam int unsigned NODE_W = idx_w(NODE_POOL),
  localparam int unsigned ROOT_W = NODE_W + 1,
  localparam int unsigned SLOT_W = (NODE_W > MAT_W) ? NODE_W : MAT_W,
  localparam int unsigned SA_W   = NODE_W + SLOT_SEL_W
) (
  input  wire logic              clk_i,
  input  wire svt_mem_cmd_t      mem_cmd_i,
  input  wire logic [CI_W-1:0]   root_addr_i,
  input  wire logic [ROOT_W-1:0] root_wdata_i,
  output logic      [ROOT_W-1:0] root_rdata_o,
  input  wire logic [NODE_W-1:0] mask_addr_i,
  input  wire logic [MASK_W-1:0] mask_wdata_i,
  output logic      [MASK_W-1:0] mask_rdata_o,
  input  wire logic [SA_W-1:0]   slot_addr_i,
  input  wire logic [SLOT_W-1:0] slot_wdata_i,
  output logic      [SLOT_W-1:0] slot_rdata_o
);

  // root entry: {is_node, node index}
  logic [ROOT_W-1:0] root_mem [CHUNKS];
  logic [MASK_W-1:0] mask_mem [NODE_POOL];
  logic [SLOT_W-1:0] slot_mem [NODE_POOL * (2 ** SLOT_SEL_W)];

  logic [ROOT_W-1:0] root_rdata_q;
  logic [MASK_W-1:0] mask_rdata_q;
  logic [SLOT_W-1:0] slot_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_cmd_i.root_we) begin
      root_mem[root_addr_i] <= root_wdata_i;
    end
    if (mem_cmd_i.root_re) begin
      root_rdata_q <= root_mem[root_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_cmd_i.mask_we) begin
      mask_mem[mask_addr_i] <= mask_wdata_i;
    end
    if (mem_cmd_i.mask_re) begin
      mask_rdata_q <= mask_mem[mask_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_cmd_i.slot_we) begin
      slot_mem[slot_addr_i] <= slot_wdata_i;
    end
    if (mem_cmd_i.slot_re) begin
      slot_rdata_q <= slot_mem[slot_addr_i];
    end
  end

  assign root_rdata_o = root_rdata_q;
  assign mask_rdata_o = mask_rdata_q;
  assign slot_rdata_o = slot_rdata_q;

endmodule

`default_nettype wire

// File: rtl/svt_ctrl.sv
// Request sequencer: walks root, root node and mid node, allocates nodes, writes back.
`default_nettype none

module svt_ctrl import svt_pkg::*; #(
  parameter int unsigned CHUNK_GRID = DEF_CHUNK_GRID,
  parameter int unsigned NODE_POOL  = DEF_NODE_POOL,
  localparam int unsigned CHUNKS = CHUNK_GRID * CHUNK_GRID * CHUNK_GRID,
  localparam int unsigned CI_W   = idx_w(CHUNKS),
  localparam int unsigned NODE_W = idx_w(NODE_POOL),
  localparam int unsigned NF_W   = $clog2(NODE_POOL + 1),
  localparam int unsigned ROOT_W = NODE_W + 1,
  localparam int unsigned SLOT_W = (NODE_W > MAT_W) ? NODE_W : MAT_W,
  localparam int unsigned SA_W   = NODE_W + SLOT_SEL_W
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               req_type_i,
  input  wire logic [COORD_W-1:0] chunk_x_i,
  input  wire logic [COORD_W-1:0] chunk_y_i,
  input  wire logic [COORD_W-1:0] chunk_z_i,
  input  wire logic [COORD_W-1:0] voxel_x_i,
  input  wire logic [COORD_W-1:0] voxel_y_i,
  input  wire logic [COORD_W-1:0] voxel_z_i,
  input  wire logic [MAT_W-1:0]   write_material_i,
  output logic                    done_o,
  output logic      [MAT_W-1:0]   read_material_o,
  output logic                    status_o,
  output svt_mem_cmd_t            mem_cmd_o,
  output logic      [CI_W-1:0]    root_addr_o,
  output logic      [ROOT_W-1:0]  root_wdata_o,
  input  wire logic [ROOT_W-1:0]  root_rdata_i,
  output logic      [NODE_W-1:0]  mask_addr_o,
  output logic      [MASK_W-1:0]  mask_wdata_o,
  input  wire logic [MASK_W-1:0]  mask_rdata_i,
  output logic      [SA_W-1:0]    slot_addr_o,
  output logic      [SLOT_W-1:0]  slot_wdata_o,
  input  wire logic [SLOT_W-1:0]  slot_rdata_i
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_ROOT  = 6'b000100,
    S_RNODE = 6'b001000,
    S_MNODE = 6'b010000,
    S_WR2   = 6'b100000
  } state_e;

  localparam logic [CI_W-1:0] LAST_CHUNK = CI_W'(CHUNKS - 1);
  localparam logic [NF_W-1:0] POOL_N     = NF_W'(NODE_POOL);
  localparam logic [NF_W-1:0] POOL_M2    = NF_W'(NODE_POOL - 2);

  state_e state_q, state_d;
  logic [CI_W-1:0]       clr_cnt_q, clr_cnt_d;
  logic [NF_W-1:0]       nf_q, nf_d;
  logic                  req_type_q, req_type_d;
  logic                  in_grid_q, in_grid_d;
  logic [CI_W-1:0]       ci_q, ci_d;
  logic [SLOT_SEL_W-1:0] child_q, child_d;
  logic [SLOT_SEL_W-1:0] leaf_q, leaf_d;
  logic [MAT_W-1:0]      mat_q, mat_d;
  logic [NODE_W-1:0]     rn_q, rn_d;
  logic [NODE_W-1:0]     mn_q, mn_d;
  logic                  done_q, done_d;
  logic [MAT_W-1:0]      rd_mat_q, rd_mat_d;
  logic                  status_q, status_d;

  logic                  in_grid_c;
  logic [CI_W-1:0]       ci_c;
  logic [NF_W-1:0]       nf_inc1;
  logic [NODE_W-1:0]     nf_node, nf_next_node;
  logic                  root_is_node;
  logic [NODE_W-1:0]     root_idx, slot_idx;

  assign in_grid_c = ({3'b000, chunk_x_i} < GRID_CMP_W'(CHUNK_GRID))
                  && ({3'b000, chunk_y_i} < GRID_CMP_W'(CHUNK_GRID))
                  && ({3'b000, chunk_z_i} < GRID_CMP_W'(CHUNK_GRID));
  assign ci_c = CI_W'(chunk_x_i) + CI_W'(CHUNK_GRID)
              * (CI_W'(chunk_y_i) + CI_W'(CHUNK_GRID) * CI_W'(chunk_z_i));

  assign nf_inc1      = nf_q + NF_W'(1);
  assign nf_node      = nf_q[NODE_W-1:0];
  assign nf_next_node = nf_inc1[NODE_W-1:0];
  assign root_is_node = root_rdata_i[NODE_W];
  assign root_idx     = root_rdata_i[NODE_W-1:0];
  assign slot_idx     = slot_rdata_i[NODE_W-1:0];

  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    nf_d         = nf_q;
    req_type_d   = req_type_q;
    in_grid_d    = in_grid_q;
    ci_d         = ci_q;
    child_d      = child_q;
    leaf_d       = leaf_q;
    mat_d        = mat_q;
    rn_d         = rn_q;
    mn_d         = mn_q;
    done_d       = 1'b0;
    rd_mat_d     = rd_mat_q;
    status_d     = status_q;
    mem_cmd_o    = '0;
    root_addr_o  = ci_q;
    root_wdata_o = '0;
    mask_addr_o  = rn_q;
    mask_wdata_o = '0;
    slot_addr_o  = {rn_q, child_q};
    slot_wdata_o = '0;

    unique case (state_q)
      S_CLEAR: begin
        // every chunk starts as an empty leaf
        mem_cmd_o.root_we = 1'b1;
        root_addr_o       = clr_cnt_q;
        clr_cnt_d         = clr_cnt_q + CI_W'(1);
        if (clr_cnt_q == LAST_CHUNK) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_type_d        = req_type_i;
          in_grid_d         = in_grid_c;
          ci_d              = in_grid_c ? ci_c : '0;
          child_d           = {voxel_z_i[3:2], voxel_y_i[3:2], voxel_x_i[3:2]};
          leaf_d            = {voxel_z_i[1:0], voxel_y_i[1:0], voxel_x_i[1:0]};
          mat_d             = write_material_i;
          mem_cmd_o.root_re = 1'b1;
          root_addr_o       = in_grid_c ? ci_c : '0;
          state_d           = S_ROOT;
        end
      end
      S_ROOT: begin
        if (!in_grid_q || (!root_is_node && req_type_q == REQ_READ)) begin
          done_d   = 1'b1;
          rd_mat_d = '0;
          status_d = STATUS_DONE;
          state_d  = S_IDLE;
        end else if (root_is_node) begin
          rn_d              = root_idx;
          mem_cmd_o.mask_re = 1'b1;
          mem_cmd_o.slot_re = 1'b1;
          mask_addr_o       = root_idx;
          slot_addr_o       = {root_idx, child_q};
          state_d           = S_RNODE;
        end else if (nf_q > POOL_M2 || NODE_POOL < 2) begin
          done_d   = 1'b1;
          rd_mat_d = '0;
          status_d = STATUS_FULL;
          state_d  = S_IDLE;
        end else begin
          // new root node and new mid node
          mem_cmd_o.root_we = 1'b1;
          root_wdata_o      = {1'b1, nf_node};
          mem_cmd_o.mask_we = 1'b1;
          mask_addr_o       = nf_node;
          mask_wdata_o      = MASK_W'(1) << child_q;
          mem_cmd_o.slot_we = 1'b1;
          slot_addr_o       = {nf_node, child_q};
          slot_wdata_o      = SLOT_W'(nf_next_node);
          mn_d              = nf_next_node;
          nf_d              = nf_q + NF_W'(2);
          state_d           = S_WR2;
        end
      end
      S_RNODE: begin
        if (mask_rdata_i[child_q]) begin
          mn_d              = slot_idx;
          mem_cmd_o.mask_re = 1'b1;
          mem_cmd_o.slot_re = 1'b1;
          mask_addr_o       = slot_idx;
          slot_addr_o       = {slot_idx, leaf_q};
          state_d           = S_MNODE;
        end else if (req_type_q == REQ_READ) begin
          done_d   = 1'b1;
          rd_mat_d = '0;
          status_d = STATUS_DONE;
          state_d  = S_IDLE;
        end else if (nf_q >= POOL_N) begin
          done_d   = 1'b1;
          rd_mat_d = '0;
          status_d = STATUS_FULL;
          state_d  = S_IDLE;
        end else begin
          // link a new mid node into the root node
          mem_cmd_o.mask_we = 1'b1;
          mask_addr_o       = rn_q;
          mask_wdata_o      = mask_rdata_i | (MASK_W'(1) << child_q);
          mem_cmd_o.slot_we = 1'b1;
          slot_addr_o       = {rn_q, child_q};
          slot_wdata_o      = SLOT_W'(nf_node);
          mn_d              = nf_node;
          nf_d              = nf_inc1;
          state_d           = S_WR2;
        end
      end
      S_MNODE: begin
        done_d   = 1'b1;
        status_d = STATUS_DONE;
        state_d  = S_IDLE;
        if (req_type_q == REQ_READ) begin
          rd_mat_d = mask_rdata_i[leaf_q] ? slot_rdata_i[MAT_W-1:0] : '0;
        end else begin
          rd_mat_d          = '0;
          mem_cmd_o.mask_we = 1'b1;
          mask_addr_o       = mn_q;
          mask_wdata_o      = mask_rdata_i | (MASK_W'(1) << leaf_q);
          mem_cmd_o.slot_we = 1'b1;
          slot_addr_o       = {mn_q, leaf_q};
          slot_wdata_o      = SLOT_W'(mat_q);
        end
      end
      S_WR2: begin
        // freshly allocated mid node: mask holds only this leaf
        mem_cmd_o.mask_we = 1'b1;
        mask_addr_o       = mn_q;
        mask_wdata_o      = MASK_W'(1) << leaf_q;
        mem_cmd_o.slot_we = 1'b1;
        slot_addr_o       = {mn_q, leaf_q};
        slot_wdata_o      = SLOT_W'(mat_q);
        done_d            = 1'b1;
        rd_mat_d          = '0;
        status_d          = STATUS_DONE;
        state_d           = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_cnt_q <= '0;
      nf_q      <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      nf_q      <= nf_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_type_q <= req_type_d;
    in_grid_q  <= in_grid_d;
    ci_q       <= ci_d;
    child_q    <= child_d;
    leaf_q     <= leaf_d;
    mat_q      <= mat_d;
    rn_q       <= rn_d;
    mn_q       <= mn_d;
    rd_mat_q   <= rd_mat_d;
    status_q   <= status_d;
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign read_material_o = rd_mat_q;
  assign status_o        = status_q;

  // a strobe is raised only on the way back to S_IDLE, which never raises it, so strobes never touch
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for two cycles");

  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nf_q <= POOL_N)
    else $error("allocation ran past the node pool");

  a_no_alloc_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_CLEAR) |=> nf_q == $past(nf_q))
    else $error("node allocated outside a transaction");

  a_full_is_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q) |-> (rd_mat_q == '0 && req_type_q == REQ_WRITE))
    else $error("pool-full status on a read or with data");

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start) |=> state_q == S_ROOT)
    else $error("accepted transaction did not start the walk");

endmodule

`default_nettype wire

// File: rtl/sparse_voxel_tree_store.sv
// Top level of the sparse voxel tree store: sequencer plus node and root storage.
//
//  channel   | handshake            | payload
//  ----------+----------------------+----------------------------------------------
//  request   | start & !busy        | req_type_i, chunk_*_i, voxel_*_i, write_material_i
//  result    | done_o (1-cycle)     | read_material_o, status_o
//
// One transaction at a time; every step is one read or write of the single-port RAMs.
// Walk: root entry, then root node, then mid node; it ends early off grid, on a read that
// misses, or with the pool full, and allocating writes end with the new mid node (S_WR2).
// After reset the root table is swept, every chunk cleared to an empty leaf, with busy high.
// Results are strobed once and cannot be stalled; a new start may come with the strobe.
`default_nettype none

module sparse_voxel_tree_store import svt_pkg::*; #(
  parameter int unsigned CHUNK_GRID = DEF_CHUNK_GRID,
  parameter int unsigned NODE_POOL  = DEF_NODE_POOL
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               req_type_i,
  input  wire logic [COORD_W-1:0] chunk_x_i,
  input  wire logic [COORD_W-1:0] chunk_y_i,
  input  wire logic [COORD_W-1:0] chunk_z_i,
  input  wire logic [COORD_W-1:0] voxel_x_i,
  input  wire logic [COORD_W-1:0] voxel_y_i,
  input  wire logic [COORD_W-1:0] voxel_z_i,
  input  wire logic [MAT_W-1:0]   write_material_i,
  output logic                    done_o,
  output logic      [MAT_W-1:0]   read_material_o,
  output logic                    status_o
);

  localparam int unsigned CHUNKS = CHUNK_GRID * CHUNK_GRID * CHUNK_GRID;
  localparam int unsigned CI_W   = idx_w(CHUNKS);
  localparam int unsigned NODE_W = idx_w(NODE_POOL);
  localparam int unsigned ROOT_W = NODE_W + 1;
  localparam int unsigned SLOT_W = (NODE_W > MAT_W) ? NODE_W : MAT_W;
  localparam int unsigned SA_W   = NODE_W + SLOT_SEL_W;

  svt_mem_cmd_t      mem_cmd;
  logic [CI_W-1:0]   root_addr;
  logic [ROOT_W-1:0] root_wdata, root_rdata;
  logic [NODE_W-1:0] mask_addr;
  logic [MASK_W-1:0] mask_wdata, mask_rdata;
  logic [SA_W-1:0]   slot_addr;
  logic [SLOT_W-1:0] slot_wdata, slot_rdata;

  svt_ctrl #(
    .CHUNK_GRID (CHUNK_GRID),
    .NODE_POOL  (NODE_POOL)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .req_type_i       (req_type_i),
    .chunk_x_i        (chunk_x_i),
    .chunk_y_i        (chunk_y_i),
    .chunk_z_i        (chunk_z_i),
    .voxel_x_i        (voxel_x_i),
    .voxel_y_i        (voxel_y_i),
    .voxel_z_i        (voxel_z_i),
    .write_material_i (write_material_i),
    .done_o           (done_o),
    .read_material_o  (read_material_o),
    .status_o         (status_o),
    .mem_cmd_o        (mem_cmd),
    .root_addr_o      (root_addr),
    .root_wdata_o     (root_wdata),
    .root_rdata_i     (root_rdata),
    .mask_addr_o      (mask_addr),
    .mask_wdata_o     (mask_wdata),
    .mask_rdata_i     (mask_rdata),
    .slot_addr_o      (slot_addr),
    .slot_wdata_o     (slot_wdata),
    .slot_rdata_i     (slot_rdata)
  );

  svt_store #(
    .CHUNK_GRID (CHUNK_GRID),
    .NODE_POOL  (NODE_POOL)
  ) u_store (
    .clk_i        (clk_i),
    .mem_cmd_i    (mem_cmd),
    .root_addr_i  (root_addr),
    .root_wdata_i (root_wdata),
    .root_rdata_o (root_rdata),
    .mask_addr_i  (mask_addr),
    .mask_wdata_i (mask_wdata),
    .mask_rdata_o (mask_rdata),
    .slot_addr_i  (slot_addr),
    .slot_wdata_i (slot_wdata),
    .slot_rdata_o (slot_rdata)
  );

endmodule

`default_nettype wire
